// ===== design/nsts_pkg.sv =====
// Shared types, widths and codes for the nested section timing statistics block.
package nsts_pkg;

    // Field widths
    localparam int TIME_BITS = 48;
    localparam int SEC_W     = 4;
    localparam int CNT_W     = 32;
    localparam int TOT_W     = 64;

    // Default sizes
    localparam int DEF_STACK_DEPTH  = 64;
    localparam int DEF_NUM_SECTIONS = 16;

    // Event kinds
    localparam logic FUNC_ENTER = 1'b0;
    localparam logic FUNC_EXIT  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // One row of the statistics table
    typedef struct packed {
        logic [CNT_W-1:0]     count;
        logic [TOT_W-1:0]     total;
        logic [TIME_BITS-1:0] min_t;
        logic [TIME_BITS-1:0] max_t;
    } stat_entry_t;

    localparam stat_entry_t STAT_RESET = '{
        count: '0,
        total: '0,
        min_t: '1,
        max_t: '0
    };

endpackage

// ===== design/nsts_stack_mem.sv =====
// Start time stack memory: one write port, one registered read port.
module nsts_stack_mem
    import nsts_pkg::*;
#(
    parameter int DEPTH = DEF_STACK_DEPTH,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [TIME_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [TIME_BITS-1:0] rd_data
);

    logic [TIME_BITS-1:0] mem [DEPTH];
    logic [TIME_BITS-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/nsts_stat_mem.sv =====
// Per-section statistics memory with a clearing pass after reset.
module nsts_stat_mem
    import nsts_pkg::*;
#(
    parameter int NUM_SECTIONS = DEF_NUM_SECTIONS,
    localparam int AW          = $clog2(NUM_SECTIONS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  stat_entry_t   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output stat_entry_t   rd_data,
    output logic          clr_busy
);

    stat_entry_t   mem [NUM_SECTIONS];
    stat_entry_t   rd_data_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // Clear sweep: one row per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(NUM_SECTIONS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Write port, shared by the sweep and the update path
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= STAT_RESET;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// ===== design/nsts_divider.sv =====
// Restoring divider: one quotient bit per cycle, total by count.
module nsts_divider
    import nsts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [TOT_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [TOT_W-1:0] quotient
);

    localparam int STEP_W = $clog2(TOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [TOT_W-1:0]  quo_reg;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_diff;
    logic              q_bit;

    // Shift-subtract step
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[TOT_W-1]};
        rem_diff = rem_sh - {1'b0, div_reg};
        q_bit    = (rem_sh >= {1'b0, div_reg});
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(TOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath; the dividend shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            quo_reg <= {quo_reg[TOT_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/nested_section_timing_stats.sv =====
// Top level: nesting stack, statistics table update and result register.
//
// Input channel (in_valid/in_stall): enter or exit events with a section id
// and a tick timestamp. Output channel (out_valid/out_stall): one result per
// exit, and one per error (exit on empty stack, enter on full stack).
// An enter on a non-full stack gives no result.
// An exit goes from transfer to result in these steps: the stack and table
// reads at the transfer, the update and write-back, the one-bit-per-cycle
// average divider, taking the quotient, then the result register load.
// The divider takes the longest; no new item is taken until an exit's result
// is loaded. Errors go from the transfer straight to the result register load.
// Items are worked one at a time; in_stall is high while an item is in flight.
// A finished result waits in the output register while out_stall is high;
// the next item is already taken, and only its own result waits for the
// register to free up.
// After reset the statistics table is swept to its reset values, one row per
// cycle, every row in turn; in_stall is high during the sweep.
// The stack level resets to zero; stack contents are not cleared.
module nested_section_timing_stats
    import nsts_pkg::*;
#(
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
    parameter int NUM_SECTIONS = DEF_NUM_SECTIONS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [SEC_W-1:0]     section_id,
    input  logic [TIME_BITS-1:0] timestamp,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SEC_W-1:0]     result_section,
    output logic [TIME_BITS-1:0] elapsed_ticks,
    output logic [CNT_W-1:0]     call_count,
    output logic [TOT_W-1:0]     total_ticks,
    output logic [TIME_BITS-1:0] min_ticks,
    output logic [TIME_BITS-1:0] max_ticks,
    output logic [TOT_W-1:0]     avg_ticks,
    output logic [1:0]           status
);

    localparam int SP_AW = $clog2(STACK_DEPTH);
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(NUM_SECTIONS);
    localparam int MOD_W = 11;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_OUT
    } state_t;

    state_t           state_reg;
    logic [LVL_W-1:0] level_reg;
    logic             out_valid_reg;

    // Work registers of the item in flight
    logic [SEC_W-1:0]     sec_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [TIME_BITS-1:0] ts_reg;
    status_t              status_reg;
    logic [TIME_BITS-1:0] el_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TOT_W-1:0]     tot_reg;
    logic [TIME_BITS-1:0] min_reg;
    logic [TIME_BITS-1:0] max_reg;
    logic [TOT_W-1:0]     avg_reg;

    // Output payload registers
    logic [SEC_W-1:0]     o_sec_reg;
    logic [TIME_BITS-1:0] o_el_reg;
    logic [CNT_W-1:0]     o_cnt_reg;
    logic [TOT_W-1:0]     o_tot_reg;
    logic [TIME_BITS-1:0] o_min_reg;
    logic [TIME_BITS-1:0] o_max_reg;
    logic [TOT_W-1:0]     o_avg_reg;
    status_t              o_status_reg;

    logic                 clr_busy;
    logic                 acc;
    logic                 stack_full;
    logic                 stack_empty;
    logic                 push;
    logic                 pop;
    logic                 err_full;
    logic                 err_empty;
    logic                 out_load;
    logic [MOD_W-1:0]     sec_mod;
    logic [IDX_W-1:0]     in_idx;
    logic [LVL_W-1:0]     level_m1;

    logic [TIME_BITS-1:0] stk_rd_data;
    stat_entry_t          tab_rd_data;
    stat_entry_t          tab_wr_data;

    logic [TIME_BITS-1:0] elapsed;
    logic [TOT_W:0]       tot_sum;
    logic                 div_done;
    logic [TOT_W-1:0]     quotient;

    // Table index: section id reduced modulo the table size
    always_comb
    begin
        sec_mod = MOD_W'(section_id);
        for (int k = 0; k < 8; k++)
        begin
            if (sec_mod >= MOD_W'(NUM_SECTIONS))
            begin
                sec_mod = sec_mod - MOD_W'(NUM_SECTIONS);
            end
        end
    end
    assign in_idx = sec_mod[IDX_W-1:0];

    // Transfer decode
    assign in_stall    = clr_busy || (state_reg != S_IDLE);
    assign acc         = in_valid && !in_stall;
    assign stack_full  = (level_reg >= LVL_W'(STACK_DEPTH));
    assign stack_empty = (level_reg == '0);
    assign push        = acc && (func == FUNC_ENTER) && !stack_full;
    assign err_full    = acc && (func == FUNC_ENTER) && stack_full;
    assign pop         = acc && (func == FUNC_EXIT) && !stack_empty;
    assign err_empty   = acc && (func == FUNC_EXIT) && stack_empty;
    assign level_m1    = level_reg - 1'b1;
    assign out_load    = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // Update of the section row from the read data
    always_comb
    begin
        elapsed           = ts_reg - stk_rd_data;
        tot_sum           = {1'b0, tab_rd_data.total} + (TOT_W + 1)'(elapsed);
        tab_wr_data.count = (tab_rd_data.count == '1) ? tab_rd_data.count
                                                       : tab_rd_data.count + 1'b1;
        tab_wr_data.total = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
        tab_wr_data.min_t = (elapsed < tab_rd_data.min_t) ? elapsed : tab_rd_data.min_t;
        tab_wr_data.max_t = (elapsed > tab_rd_data.max_t) ? elapsed : tab_rd_data.max_t;
    end

    nsts_stack_mem #(
        .DEPTH   (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (level_reg[SP_AW-1:0]),
        .wr_data (timestamp),
        .rd_en   (pop),
        .rd_addr (level_m1[SP_AW-1:0]),
        .rd_data (stk_rd_data)
    );

    nsts_stat_mem #(
        .NUM_SECTIONS (NUM_SECTIONS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (state_reg == S_CALC),
        .wr_addr  (idx_reg),
        .wr_data  (tab_wr_data),
        .rd_en    (pop),
        .rd_addr  (in_idx),
        .rd_data  (tab_rd_data),
        .clr_busy (clr_busy)
    );

    nsts_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_CALC),
        .dividend (tab_wr_data.total),
        .divisor  (tab_wr_data.count),
        .done     (div_done),
        .quotient (quotient)
    );

    // Sequencer, stack level and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (push)
                    begin
                        level_reg <= level_reg + 1'b1;
                    end
                    else if (pop)
                    begin
                        level_reg <= level_m1;
                        state_reg <= S_CALC;
                    end
                    else if (err_full || err_empty)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_CALC:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Work registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            sec_reg    <= section_id;
            idx_reg    <= in_idx;
            ts_reg     <= timestamp;
            status_reg <= err_full ? STATUS_FULL : (err_empty ? STATUS_EMPTY : STATUS_OK);
            el_reg     <= '0;
            cnt_reg    <= '0;
            tot_reg    <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            avg_reg    <= '0;
        end
        else if (state_reg == S_CALC)
        begin
            el_reg  <= elapsed;
            cnt_reg <= tab_wr_data.count;
            tot_reg <= tab_wr_data.total;
            min_reg <= tab_wr_data.min_t;
            max_reg <= tab_wr_data.max_t;
        end
        else if ((state_reg == S_DIV) && div_done)
        begin
            avg_reg <= quotient;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_sec_reg    <= sec_reg;
            o_el_reg     <= el_reg;
            o_cnt_reg    <= cnt_reg;
            o_tot_reg    <= tot_reg;
            o_min_reg    <= min_reg;
            o_max_reg    <= max_reg;
            o_avg_reg    <= avg_reg;
            o_status_reg <= status_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_section = o_sec_reg;
    assign elapsed_ticks  = o_el_reg;
    assign call_count     = o_cnt_reg;
    assign total_ticks    = o_tot_reg;
    assign min_ticks      = o_min_reg;
    assign max_ticks      = o_max_reg;
    assign avg_ticks      = o_avg_reg;
    assign status         = o_status_reg;

endmodule

// ===== test/tb_nested_section_timing_stats.sv =====
// Testbench for the nested section timing statistics block, checked against a local predictor.
module tb_nested_section_timing_stats
    import nsts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = DEF_STACK_DEPTH;
    localparam int SECTIONS   = DEF_NUM_SECTIONS;
    localparam int RAND_ITEMS = 750;
    localparam int IDLE_LIMIT = 3000;
    localparam int CALM_ITEMS = 80;

    typedef struct {
        logic                 kind;
        logic [SEC_W-1:0]     sec;
        logic [TIME_BITS-1:0] stamp;
    } section_event_t;

    typedef struct {
        logic [SEC_W-1:0]     sec;
        logic [TIME_BITS-1:0] elapsed;
        logic [CNT_W-1:0]     count;
        logic [TOT_W-1:0]     total;
        logic [TIME_BITS-1:0] min_t;
        logic [TIME_BITS-1:0] max_t;
        logic [TOT_W-1:0]     avg;
        status_t              st;
    } section_stats_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 func = FUNC_ENTER;
    logic [SEC_W-1:0]     section_id = '0;
    logic [TIME_BITS-1:0] timestamp = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [SEC_W-1:0]     result_section;
    logic [TIME_BITS-1:0] elapsed_ticks;
    logic [CNT_W-1:0]     call_count;
    logic [TOT_W-1:0]     total_ticks;
    logic [TIME_BITS-1:0] min_ticks;
    logic [TIME_BITS-1:0] max_ticks;
    logic [TOT_W-1:0]     avg_ticks;
    logic [1:0]           status;

    nested_section_timing_stats uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .section_id     (section_id),
        .timestamp      (timestamp),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_section (result_section),
        .elapsed_ticks  (elapsed_ticks),
        .call_count     (call_count),
        .total_ticks    (total_ticks),
        .min_ticks      (min_ticks),
        .max_ticks      (max_ticks),
        .avg_ticks      (avg_ticks),
        .status         (status)
    );

    // Predictor state: start time stack and per-section statistics
    logic [TIME_BITS-1:0] start_times [DEPTH];
    int                   nest_level;
    logic [CNT_W-1:0]     sec_count [SECTIONS];
    logic [TOT_W-1:0]     sec_total [SECTIONS];
    logic [TIME_BITS-1:0] sec_min   [SECTIONS];
    logic [TIME_BITS-1:0] sec_max   [SECTIONS];

    section_event_t pending_events [$];
    section_stats_t stats_due [$];

    int  err_count;
    int  n_events, n_exits, n_empty, n_full, peak_level;
    int  gap_left, stall_left, idle_cycles;
    logic in_taken = 1'b0;
    logic [TIME_BITS-1:0] tick_clock;
    int  gen_level, gen_count, fill_runs;

    // Append one expected result
    task automatic expect_result(input section_stats_t res);
        stats_due.insert(stats_due.size(), res);
    endtask

    // Work out what one accepted event should produce
    task automatic track_event(input section_event_t ev);
        section_stats_t   res;
        logic [TOT_W:0]   sum;
        int               idx;
        idx = ev.sec % SECTIONS;
        res = '{sec: ev.sec, elapsed: '0, count: '0, total: '0, min_t: '0, max_t: '0,
                avg: '0, st: STATUS_OK};
        n_events++;
        if (ev.kind == FUNC_ENTER)
        begin
            if (nest_level >= DEPTH)
            begin
                res.st = STATUS_FULL;
                n_full++;
                expect_result(res);
            end
            else
            begin
                start_times[nest_level] = ev.stamp;
                nest_level++;
                if (nest_level > peak_level)
                    peak_level = nest_level;
            end
        end
        else if (nest_level == 0)
        begin
            res.st = STATUS_EMPTY;
            n_empty++;
            expect_result(res);
        end
        else
        begin
            nest_level--;
            res.elapsed = ev.stamp - start_times[nest_level];
            if (sec_count[idx] != '1)
                sec_count[idx]++;
            sum = {1'b0, sec_total[idx]} + (TOT_W + 1)'(res.elapsed);
            sec_total[idx] = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
            if (res.elapsed < sec_min[idx])
                sec_min[idx] = res.elapsed;
            if (res.elapsed > sec_max[idx])
                sec_max[idx] = res.elapsed;
            res.count = sec_count[idx];
            res.total = sec_total[idx];
            res.min_t = sec_min[idx];
            res.max_t = sec_max[idx];
            res.avg   = sec_total[idx] / {{(TOT_W-CNT_W){1'b0}}, sec_count[idx]};
            n_exits++;
            expect_result(res);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            err_count++;
        end
    endtask

    task automatic queue_event(input logic kind, input logic [SEC_W-1:0] sec,
                               input logic [TIME_BITS-1:0] stamp);
        section_event_t ev;
        ev = '{kind: kind, sec: sec, stamp: stamp};
        pending_events.insert(pending_events.size(), ev);
    endtask

    // Mostly advancing time, sometimes a jump anywhere in the counter range
    function automatic logic [TIME_BITS-1:0] next_stamp();
        if ($urandom_range(0, 9) == 0)
            tick_clock = TIME_BITS'({$urandom, $urandom});
        else if ($urandom_range(0, 9) == 0)
            tick_clock += TIME_BITS'({$urandom, $urandom} >> $urandom_range(0, 40));
        else
            tick_clock += TIME_BITS'($urandom_range(0, 5000));
        return tick_clock;
    endfunction

    task automatic gen_item(input logic kind);
        queue_event(kind, SEC_W'($urandom_range(0, 15)), next_stamp());
        gen_count++;
        if (kind == FUNC_ENTER && gen_level < DEPTH)
            gen_level++;
        else if (kind == FUNC_EXIT && gen_level > 0)
            gen_level--;
    endtask

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Transfer on the input side feeds the predictor
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            track_event('{kind: func, sec: section_id, stamp: timestamp});
    end

    // Input driver with random gap bursts
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_events.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (pending_events.size() > CALM_ITEMS && $urandom_range(0, 99) < 20)
            begin
                gap_left = $urandom_range(1, 9) - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                section_event_t ev;
                ev = pending_events.pop_front();
                in_valid   <= 1'b1;
                func       <= ev.kind;
                section_id <= ev.sec;
                timestamp  <= ev.stamp;
            end
        end
    end

    // Output stall bursts, none near the end
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (rst_n && pending_events.size() > CALM_ITEMS &&
                 $urandom_range(0, 99) < 15)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (stats_due.size() == 0)
            begin
                $error("result with nothing expected: section %0h status %0d",
                       result_section, status);
                err_count++;
            end
            else
            begin
                section_stats_t want;
                want = stats_due.pop_front();
                check_field("result_section", 64'(want.sec), 64'(result_section));
                check_field("elapsed_ticks", 64'(want.elapsed), 64'(elapsed_ticks));
                check_field("call_count", 64'(want.count), 64'(call_count));
                check_field("total_ticks", want.total, total_ticks);
                check_field("min_ticks", 64'(want.min_t), 64'(min_ticks));
                check_field("max_ticks", 64'(want.max_t), 64'(max_ticks));
                check_field("avg_ticks", want.avg, avg_ticks);
                check_field("status", 64'(want.st), 64'(status));
            end
        end
    end

    // Watchdog: too long without a transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        err_count = 0;
        n_events = 0; n_exits = 0; n_empty = 0; n_full = 0; peak_level = 0;
        gap_left = 0; stall_left = 0; idle_cycles = 0;
        nest_level = 0;
        for (int i = 0; i < SECTIONS; i++)
        begin
            sec_count[i] = '0;
            sec_total[i] = '0;
            sec_min[i]   = '1;
            sec_max[i]   = '0;
        end

        // Directed: empty-stack exit, zero and full-range durations, wrap,
        // nesting, exit naming another section
        queue_event(FUNC_EXIT, 4'h0, '0);
        queue_event(FUNC_ENTER, 4'h0, '0);
        queue_event(FUNC_EXIT, 4'h0, '0);
        queue_event(FUNC_ENTER, 4'hF, '1);
        queue_event(FUNC_EXIT, 4'hF, '1 - 1);
        queue_event(FUNC_ENTER, 4'hF, '1);
        queue_event(FUNC_EXIT, 4'hF, '0);
        queue_event(FUNC_ENTER, 4'h3, 48'd100);
        queue_event(FUNC_ENTER, 4'h5, 48'd150);
        queue_event(FUNC_EXIT, 4'h5, 48'd400);
        queue_event(FUNC_EXIT, 4'h3, 48'd1000);
        queue_event(FUNC_ENTER, 4'h7, 48'hAAAA_AAAA_AAAA);
        queue_event(FUNC_EXIT, 4'h9, 48'hFFFF_5555_5555);
        queue_event(FUNC_EXIT, 4'hF, '1);
        queue_event(FUNC_ENTER, 4'hA, 48'h8000_0000_0000);
        queue_event(FUNC_EXIT, 4'hA, 48'h8000_0000_0001);

        // Random: mostly balanced nesting, with full-stack fills and
        // drains past empty now and then
        tick_clock = TIME_BITS'({$urandom, $urandom});
        gen_level = 0;
        gen_count = 0;
        fill_runs = 0;
        while (gen_count < RAND_ITEMS)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 2 || (fill_runs == 0 && gen_count > 300))
            begin
                int extra;
                fill_runs++;
                while (gen_level < DEPTH)
                    gen_item(FUNC_ENTER);
                extra = $urandom_range(1, 3);
                for (int i = 0; i < extra; i++)
                    gen_item(FUNC_ENTER);
                extra = $urandom_range(1, DEPTH);
                for (int i = 0; i < extra; i++)
                    gen_item(FUNC_EXIT);
            end
            else if (r < 6)
            begin
                int extra;
                while (gen_level > 0)
                    gen_item(FUNC_EXIT);
                extra = $urandom_range(1, 2);
                for (int i = 0; i < extra; i++)
                    gen_item(FUNC_EXIT);
            end
            else
            begin
                gen_item(($urandom_range(0, 99) < (gen_level < 6 ? 60 : 40)) ?
                         FUNC_ENTER : FUNC_EXIT);
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_events.size() == 0 && !in_valid);
        wait (stats_due.size() == 0);
        repeat (100) @(posedge clk);

        $display("Covered %0d events: %0d section exits, %0d empty-stack exits,",
                 n_events, n_exits, n_empty);
        $display("%0d full-stack enters; deepest nesting %0d of %0d, %0d stack fills",
                 n_full, peak_level, DEPTH, fill_runs);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
